/* hdl/tcgr_pkg.sv */
// shared types and constants of the text cursor glyph renderer
package tcgr_pkg;

    // glyph geometry: one blank spacing column follows the glyph columns
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 8;
    localparam int CELL_COLS   = GLYPH_COLS + 1;
    localparam int CELL_COUNT  = CELL_COLS * GLYPH_ROWS;
    localparam int GLYPH_BITS  = 8 * GLYPH_COLS;
    localparam int ROW_IDX_W   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // special character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_RETURN  = 8'd13;

    // register reset values
    localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd128;
    localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd64;
    localparam logic [7:0]  RST_TEXT_SCALE    = 8'd1;
    localparam logic        RST_WRAP_ENABLE   = 1'b1;
    localparam logic [15:0] RST_FG_COLOR      = 16'hFFFF;
    localparam logic [15:0] RST_BG_COLOR      = 16'hFFFF;

    typedef enum logic {
        CMD_RENDER     = 1'b0,
        CMD_SET_CURSOR = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_TEXT_SCALE    = 3'd2,
        REG_WRAP_ENABLE   = 3'd3,
        REG_FG_COLOR      = 3'd4,
        REG_BG_COLOR      = 3'd5
    } reg_idx_t;

    // configuration as seen by front and back; scale is already forced nonzero
    typedef struct packed {
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic [7:0]  scale;
        logic        wrap_enable;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } tcgr_cfg_t;

    // one character to draw: corner plus which cells write and which are foreground
    typedef struct packed {
        logic [15:0]           x;
        logic [15:0]           y;
        logic [CELL_COUNT-1:0] emit_mask;
        logic [CELL_COUNT-1:0] fg_mask;
    } tcgr_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tcgr_queue_stat_t;

endpackage

/* hdl/text_cursor_glyph_renderer_top.sv */
// Text cursor glyph renderer: 5x8 font characters to square fill writes.
// With the back idle, the first write passes through the queue slot, the job registers of
// the back and its output registers; each non-writing cell ahead of it adds a walk step.
// The back walks one glyph cell per cycle while the output is not held, through up to 48
// cells after a job load; a character ends early after its last writing cell.
// Cursor, newline and clipped characters are taken at one per cycle while the queue has room.
// Reset (rst_n low, asynchronous) clears cursor, queue and output, and loads register defaults.
module text_cursor_glyph_renderer_top #(
    parameter int QUEUE_DEPTH = tcgr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // char_code[7:0], glyph_columns[47:8], new_x[63:48], new_y[79:64]
    input  logic        s_axis_tuser,   // cmd
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pixel_x[15:0], pixel_y[31:16], pixel_color[47:32], block_size[55:48]
    output logic        m_axis_tlast,   // last
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tcgr_pkg::*;

    logic [10:0]      screen_width_reg, screen_height_reg;
    logic [7:0]       text_scale_reg;
    logic             wrap_enable_reg;
    logic [15:0]      fg_color_reg, bg_color_reg;
    tcgr_cfg_t        cfg;
    tcgr_queue_stat_t q_stat;
    tcgr_job_t        push_job, head_job;
    logic             q_push, q_pop;
    logic [15:0]      out_x, out_y, out_color;
    logic [7:0]       out_size;

    // register file
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            text_scale_reg    <= RST_TEXT_SCALE;
            wrap_enable_reg   <= RST_WRAP_ENABLE;
            fg_color_reg      <= RST_FG_COLOR;
            bg_color_reg      <= RST_BG_COLOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[10:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[10:0];
                REG_TEXT_SCALE:    text_scale_reg    <= cfg_data[7:0];
                REG_WRAP_ENABLE:   wrap_enable_reg   <= cfg_data[0];
                REG_FG_COLOR:      fg_color_reg      <= cfg_data;
                REG_BG_COLOR:      bg_color_reg      <= cfg_data;
                default:           wrap_enable_reg   <= wrap_enable_reg;
            endcase
        end
    end

    // effective configuration, a zero scale acts as one
    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;
    assign cfg.scale         = (text_scale_reg == 8'd0) ? 8'd1 : text_scale_reg;
    assign cfg.wrap_enable   = wrap_enable_reg;
    assign cfg.fg_color      = fg_color_reg;
    assign cfg.bg_color      = bg_color_reg;

    tcgr_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_cmd           (s_axis_tuser),
        .in_char_code     (s_axis_tdata[7:0]),
        .in_glyph_columns (s_axis_tdata[47:8]),
        .in_new_x         (s_axis_tdata[63:48]),
        .in_new_y         (s_axis_tdata[79:64]),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_job            (push_job)
    );

    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    tcgr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_stat          (q_stat),
        .q_head          (head_job),
        .q_pop           (q_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_pixel_x     (out_x),
        .out_pixel_y     (out_y),
        .out_pixel_color (out_color),
        .out_block_size  (out_size),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {out_size, out_color, out_y, out_x};

`ifndef SYNTHESIS
    // queue never reports full and empty together
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    // every emitted square has a nonzero edge
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[55:48] != 8'd0))
        else $error("square write with zero size");
`endif

endmodule

/* hdl/tcgr_queue.sv */
// small job queue between the front and the back
module tcgr_queue #(
    parameter int DEPTH = tcgr_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tcgr_pkg::tcgr_job_t        push_job,
    input  logic                       pop,
    output tcgr_pkg::tcgr_job_t        head_job,
    output tcgr_pkg::tcgr_queue_stat_t stat
);
    import tcgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    tcgr_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // status and head
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // pointer and count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/tcgr_front.sv */
// front: takes items, keeps the cursor, wraps and clips, queues draw jobs
module tcgr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcgr_pkg::tcgr_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_cmd,
    input  logic [7:0]                      in_char_code,
    input  logic [tcgr_pkg::GLYPH_BITS-1:0] in_glyph_columns,
    input  logic [15:0]                     in_new_x,
    input  logic [15:0]                     in_new_y,
    input  tcgr_pkg::tcgr_queue_stat_t      q_stat,
    output logic                            q_push,
    output tcgr_pkg::tcgr_job_t             q_job
);
    import tcgr_pkg::*;

    logic [15:0]           cursor_col_reg, cursor_col_next;
    logic [15:0]           cursor_row_reg, cursor_row_next;
    logic [10:0]           adv, line;
    logic [15:0]           row_down;
    logic signed [17:0]    col_ext, x_ext, y_ext, width_ext, height_ext, adv_ext, line_ext;
    logic                  wrap_hit, clipped, accept, is_glyph, opaque;
    logic [15:0]           x16, y16;
    logic [CELL_COUNT-1:0] emit_mask, fg_mask;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // scaled cell advance (6 * scale) and line height (8 * scale)
    assign adv  = {1'b0, cfg.scale, 2'b00} + {2'b00, cfg.scale, 1'b0};
    assign line = {cfg.scale, 3'b000};

    assign adv_ext    = $signed({7'b0, adv});
    assign line_ext   = $signed({7'b0, line});
    assign width_ext  = $signed({7'b0, cfg.screen_width});
    assign height_ext = $signed({7'b0, cfg.screen_height});
    assign col_ext    = $signed({{2{cursor_col_reg[15]}}, cursor_col_reg});
    assign row_down   = cursor_row_reg + {5'b0, line};

    // wrap to a new line when the cell would reach the right edge
    assign wrap_hit = cfg.wrap_enable && ((col_ext + adv_ext) >= width_ext);
    assign x16      = wrap_hit ? 16'd0 : cursor_col_reg;
    assign y16      = wrap_hit ? row_down : cursor_row_reg;
    assign x_ext    = $signed({{2{x16[15]}}, x16});
    assign y_ext    = $signed({{2{y16[15]}}, y16});

    // whole-character clip against the screen
    assign clipped = (x_ext >= width_ext) || (y_ext >= height_ext) ||
                     ((x_ext + adv_ext) <= 18'sd0) || ((y_ext + line_ext) <= 18'sd0);

    // cell masks, column-major with rows innermost
    assign opaque = (cfg.bg_color != cfg.fg_color);
    always_comb
    begin
        for (int i = 0; i < CELL_COLS; i++)
        begin
            for (int j = 0; j < GLYPH_ROWS; j++)
            begin
                if (i < GLYPH_COLS)
                begin
                    fg_mask[i*GLYPH_ROWS + j] = in_glyph_columns[8*i + j];
                end
                else
                begin
                    fg_mask[i*GLYPH_ROWS + j] = 1'b0;
                end
                emit_mask[i*GLYPH_ROWS + j] = fg_mask[i*GLYPH_ROWS + j] || opaque;
            end
        end
    end

    assign is_glyph = (in_cmd == CMD_RENDER) && (in_char_code != CHAR_NEWLINE) &&
                      (in_char_code != CHAR_RETURN);

    // job to the back
    assign q_push          = accept && is_glyph && !clipped && (emit_mask != '0);
    assign q_job.x         = x16;
    assign q_job.y         = y16;
    assign q_job.emit_mask = emit_mask;
    assign q_job.fg_mask   = fg_mask;

    // cursor update
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (accept)
        begin
            priority if (in_cmd == CMD_SET_CURSOR)
            begin
                cursor_col_next = in_new_x;
                cursor_row_next = in_new_y;
            end
            else if (in_char_code == CHAR_NEWLINE)
            begin
                cursor_col_next = 16'd0;
                cursor_row_next = row_down;
            end
            else if (in_char_code == CHAR_RETURN)
            begin
                cursor_col_next = cursor_col_reg;
            end
            else
            begin
                cursor_col_next = x16 + {5'b0, adv};
                cursor_row_next = y16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

/* hdl/tcgr_back.sv */
// back: walks the cells of each job and emits up to one square write per cycle while the output is not held
module tcgr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcgr_pkg::tcgr_cfg_t        cfg,
    input  tcgr_pkg::tcgr_queue_stat_t q_stat,
    input  tcgr_pkg::tcgr_job_t        q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [15:0]                out_pixel_x,
    output logic [15:0]                out_pixel_y,
    output logic [15:0]                out_pixel_color,
    output logic [7:0]                 out_block_size,
    output logic                       out_last
);
    import tcgr_pkg::*;

    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(GLYPH_ROWS - 1);

    logic                  active_reg;
    logic                  out_valid_reg;
    logic [15:0]           base_x_reg, base_y_reg;
    logic [15:0]           xoff_reg, yoff_reg;
    logic [ROW_IDX_W-1:0]  row_reg;
    logic [CELL_COUNT-1:0] emit_reg, fg_reg;
    logic [15:0]           out_x_reg, out_y_reg, out_color_reg;
    logic [7:0]            out_size_reg;
    logic                  out_last_reg;
    logic                  out_free, step, rest_empty;

    assign out_free   = !out_valid_reg || out_ready;
    assign step       = active_reg && out_free;
    assign q_pop      = !active_reg && !q_stat.empty;
    assign rest_empty = (emit_reg[CELL_COUNT-1:1] == '0);

    assign out_valid       = out_valid_reg;
    assign out_pixel_x     = out_x_reg;
    assign out_pixel_y     = out_y_reg;
    assign out_pixel_color = out_color_reg;
    assign out_block_size  = out_size_reg;
    assign out_last        = out_last_reg;

    // control: job load, cell walk, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step && emit_reg[0])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                active_reg <= 1'b1;
            end
            else if (step && rest_empty)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // job datapath and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            base_x_reg <= q_head.x;
            base_y_reg <= q_head.y;
            emit_reg   <= q_head.emit_mask;
            fg_reg     <= q_head.fg_mask;
            xoff_reg   <= '0;
            yoff_reg   <= '0;
            row_reg    <= '0;
        end
        else if (step)
        begin
            if (emit_reg[0])
            begin
                out_x_reg     <= base_x_reg + xoff_reg;
                out_y_reg     <= base_y_reg + yoff_reg;
                out_color_reg <= fg_reg[0] ? cfg.fg_color : cfg.bg_color;
                out_size_reg  <= cfg.scale;
                out_last_reg  <= rest_empty;
            end
            emit_reg <= emit_reg >> 1;
            fg_reg   <= fg_reg >> 1;
            if (row_reg == LAST_ROW)
            begin
                row_reg  <= '0;
                yoff_reg <= '0;
                xoff_reg <= xoff_reg + {8'b0, cfg.scale};
            end
            else
            begin
                row_reg  <= row_reg + 1'b1;
                yoff_reg <= yoff_reg + {8'b0, cfg.scale};
            end
        end
    end

endmodule

/* sim/tb_text_cursor_glyph_renderer_top.sv */
// testbench of the text cursor glyph renderer: predicted square writes checked item by item
module tb_text_cursor_glyph_renderer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcgr_pkg::*;

    // cycles without any handshake before the run is abandoned
    localparam int STALL_LIMIT  = 4000;
    // settle time after the last expected square, covers one full glyph walk
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 36;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] color;
        logic [7:0]  size;
        logic        last;
    } glyph_square_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // char_code, glyph_columns, new_x, new_y
    logic        s_axis_tuser = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // pixel_x, pixel_y, pixel_color, block_size
    logic        m_axis_tlast;        // last
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state: register copies and text cursor
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [7:0]  cfg_scale;
    logic        cfg_wrap;
    logic [15:0] cfg_fg;
    logic [15:0] cfg_bg;
    logic [15:0] cursor_col;
    logic [15:0] cursor_row;

    glyph_square_t expected_squares[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  rx_hold = 0;
    bit  no_idle = 1'b0;

    text_cursor_glyph_renderer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // compute the square writes one input item causes and advance the cursor
    task automatic predict_glyph_squares(cmd_t cmd, logic [7:0] code, logic [39:0] glyph,
                                         logic [15:0] nx, logic [15:0] ny);
        int s;
        int adv;
        int line;
        int x;
        int y;
        int w;
        int h;
        logic [7:0] colbits;
        glyph_square_t sq;
        glyph_square_t batch[$];
        s = (cfg_scale == 8'd0) ? 1 : int'(cfg_scale);
        adv = s * CELL_COLS;
        line = s * GLYPH_ROWS;
        w = int'(cfg_width);
        h = int'(cfg_height);
        if (cmd == CMD_SET_CURSOR)
        begin
            cursor_col = nx;
            cursor_row = ny;
        end
        else if (code == CHAR_NEWLINE)
        begin
            cursor_row = cursor_row + 16'(line);
            cursor_col = '0;
        end
        else if (code != CHAR_RETURN)
        begin
            x = int'($signed(cursor_col));
            // wrap before drawing when the cell would reach the right edge
            if (cfg_wrap && x + adv >= w)
            begin
                cursor_col = '0;
                cursor_row = cursor_row + 16'(line);
            end
            x = int'($signed(cursor_col));
            y = int'($signed(cursor_row));
            // whole-character clip against the screen
            if (!(x >= w || y >= h || x + adv - 1 < 0 || y + line - 1 < 0))
            begin
                for (int i = 0; i < CELL_COLS; i++)
                begin
                    colbits = 8'h00;
                    if (i < GLYPH_COLS)
                        colbits = glyph[8*i +: 8];
                    for (int j = 0; j < GLYPH_ROWS; j++)
                    begin
                        if (colbits[j])
                            sq.color = cfg_fg;
                        else if (cfg_bg != cfg_fg)
                            sq.color = cfg_bg;
                        else
                            continue;
                        sq.px = 16'(x + i * s);
                        sq.py = 16'(y + j * s);
                        sq.size = 8'(s);
                        sq.last = 1'b0;
                        batch.push_back(sq);
                    end
                end
                if (batch.size() > 0)
                    batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k])
                    expected_squares.push_back(batch[k]);
            end
            cursor_col = cursor_col + 16'(adv);
        end
    endtask

    // send one input item after a random gap; valid stays high for a back-to-back item
    task automatic send_item(cmd_t cmd, logic [7:0] code, logic [39:0] glyph,
                             logic [15:0] nx, logic [15:0] ny);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ny, nx, glyph, code};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_glyph_squares(cmd, code, glyph, nx, ny);
    endtask

    task automatic put_char(logic [7:0] code, logic [39:0] glyph);
        send_item(CMD_RENDER, code, glyph, 16'(int'($urandom)), 16'(int'($urandom)));
    endtask

    task automatic set_cursor(logic [15:0] nx, logic [15:0] ny);
        send_item(CMD_SET_CURSOR, 8'($urandom), 40'({$urandom, $urandom}), nx, ny);
    endtask

    // stop sending and wait for every expected square, then let the back settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_width  = val[10:0];
            REG_SCREEN_HEIGHT: cfg_height = val[10:0];
            REG_TEXT_SCALE:    cfg_scale  = val[7:0];
            REG_WRAP_ENABLE:   cfg_wrap   = val[0];
            REG_FG_COLOR:      cfg_fg     = val;
            REG_BG_COLOR:      cfg_bg     = val;
            default: ;
        endcase
    endtask

    // write all registers while the block is idle
    task automatic set_config(int w, int h, int s, bit wrap, logic [15:0] fg, logic [15:0] bg);
        drain_results();
        write_reg(REG_SCREEN_WIDTH, 16'(w));
        write_reg(REG_SCREEN_HEIGHT, 16'(h));
        write_reg(REG_TEXT_SCALE, 16'(s));
        write_reg(REG_WRAP_ENABLE, 16'(wrap));
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
        cfg_valid <= 1'b0;
    endtask

    // reset defaults: transparent background, wrap and clipping at each edge
    task automatic test_default_config();
        put_char(8'h41, 40'h7E1111117E);
        put_char(CHAR_RETURN, 40'hFFFFFFFFFF);
        put_char(CHAR_NEWLINE, 40'hFFFFFFFFFF);
        set_cursor(-16'sd3, -16'sd2);
        put_char(8'hFF, 40'hFFFFFFFFFF);
        set_cursor(-16'sd6, 16'd0);
        put_char(8'h00, 40'hFFFFFFFFFF);
        put_char(8'h30, 40'h3E4549513E);
        set_cursor(16'd0, -16'sd8);
        put_char(8'h31, 40'hFFFFFFFFFF);
        set_cursor(16'd120, 16'd0);
        put_char(8'h32, 40'h4649515162);
        set_cursor(16'd0, 16'd64);
        put_char(8'h33, 40'hFFFFFFFFFF);
        // set-cursor item that carries the newline code is still a cursor load
        send_item(CMD_SET_CURSOR, CHAR_NEWLINE, 40'h0, 16'h7FFF, 16'd4);
        put_char(8'h34, 40'h0102040810);
    endtask

    // opaque background, zero scale, no wrap, 16-bit cursor wrap-around
    task automatic test_opaque_and_cursor_wrap();
        set_config(1024, 1024, 0, 1'b0, 16'h0000, 16'hFFFF);
        set_cursor(-16'sd5, 16'd0);
        put_char(8'h00, 40'h0000000000);
        set_cursor(16'h7FFE, 16'd0);
        put_char(8'h80, 40'hFFFFFFFFFF);
        put_char(8'h81, 40'hFFFFFFFFFF);
        set_cursor(16'd0, 16'h7FFC);
        put_char(CHAR_NEWLINE, 40'h0);
        put_char(8'h82, 40'hA5A5A5A5A5);
        set_cursor(16'd1010, 16'd1016);
        put_char(8'h83, 40'h5A5A5A5A5A);
    endtask

    // largest scale and screen sizes: wrap before the second and third characters, the third clipped at the bottom
    task automatic test_large_scale();
        set_config(2047, 2047, 255, 1'b1, 16'h1234, 16'hABCD);
        set_cursor(16'd0, 16'd0);
        put_char(8'h41, 40'h7E1111117E);
        put_char(8'h42, 40'h3649494936);
        put_char(8'h43, 40'h2241414141);
    endtask

    // zero width clips everything at column 0 or beyond; blank transparent glyph writes nothing
    task automatic test_zero_width_transparent();
        set_config(0, 1, 2, 1'b0, 16'h0000, 16'h0000);
        set_cursor(16'd0, 16'd0);
        put_char(8'h20, 40'hFFFFFFFFFF);
        set_cursor(-16'sd5, -16'sd3);
        put_char(8'h20, 40'h0000000000);
        set_cursor(-16'sd5, -16'sd3);
        put_char(8'h21, 40'h8040201008);
    endtask

    // random configurations, each followed by a stream of mostly drawable characters
    task automatic test_random_phases();
        int w;
        int h;
        int s;
        int r;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [39:0] glyph;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w = ($urandom_range(0, 3) != 0) ? $urandom_range(16, 256) : $urandom_range(1, 1024);
            h = ($urandom_range(0, 3) != 0) ? $urandom_range(16, 256) : $urandom_range(1, 1024);
            r = $urandom_range(0, 9);
            s = (r < 7) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 16)
                                                         : $urandom_range(0, 255);
            fg = 16'($urandom);
            bg = ($urandom_range(0, 9) < 3) ? fg : 16'($urandom);
            set_config(w, h, s, 1'($urandom), fg, bg);
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    put_char(CHAR_NEWLINE, 40'({$urandom, $urandom}));
                else if (r < 11)
                    put_char(CHAR_RETURN, 40'({$urandom, $urandom}));
                else if (r < 24)
                begin
                    if ($urandom_range(0, 4) == 0)
                        set_cursor(16'($urandom), 16'($urandom));
                    else
                        set_cursor(16'(int'($urandom_range(0, w + 8)) - 8),
                                   16'(int'($urandom_range(0, h + 8)) - 8));
                end
                else
                begin
                    r = $urandom_range(0, 9);
                    glyph = (r < 7) ? 40'({$urandom, $urandom}) :
                            (r == 7) ? 40'h0 :
                            (r == 8) ? 40'hFFFFFFFFFF : 40'(1) << $urandom_range(0, 39);
                    put_char(8'($urandom), glyph);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= pick_gap();
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // compare each accepted square against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_squares.size() == 0)
            begin
                $error("unexpected square write: tdata 0x%0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                check_field("pixel_x", 32'(expected_squares[0].px), 32'(m_axis_tdata[15:0]));
                check_field("pixel_y", 32'(expected_squares[0].py), 32'(m_axis_tdata[31:16]));
                check_field("pixel_color", 32'(expected_squares[0].color),
                            32'(m_axis_tdata[47:32]));
                check_field("block_size", 32'(expected_squares[0].size),
                            32'(m_axis_tdata[55:48]));
                check_field("last", 32'(expected_squares[0].last), 32'(m_axis_tlast));
                void'(expected_squares.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("text_cursor_glyph_renderer_top verification failed");
            $finish;
        end
    end

    initial
    begin
        cfg_width  = RST_SCREEN_WIDTH;
        cfg_height = RST_SCREEN_HEIGHT;
        cfg_scale  = RST_TEXT_SCALE;
        cfg_wrap   = RST_WRAP_ENABLE;
        cfg_fg     = RST_FG_COLOR;
        cfg_bg     = RST_BG_COLOR;
        cursor_col = '0;
        cursor_row = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_opaque_and_cursor_wrap();
        test_large_scale();
        test_zero_width_transparent();
        test_random_phases();
        drain_results();
        if (fail_count == 0)
            $display("text_cursor_glyph_renderer_top verification clean");
        else
            $display("text_cursor_glyph_renderer_top verification failed");
        $finish;
    end

endmodule
